[hdl/sliding_window_send_limiter_top_macros.svh]
// Assertion macros shared by the send limiter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SLIDING_WINDOW_SEND_LIMITER_TOP_MACROS_SVH
`define SLIDING_WINDOW_SEND_LIMITER_TOP_MACROS_SVH

// Plain invariant, checked every cycle.
`define SWSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SWSL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/swsl_pkg.sv]
// Shared types and constants of the sliding-window send limiter.
// No dependencies; used by the output buffer and the top level.
package swsl_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int PTR_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int TICK_W    = 16;
    localparam int BYTES_W   = 20;
    localparam int DATA_W    = 32;
    localparam int WIN_W     = 14;
    localparam int SUM_W     = DATA_W + CNT_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 14'd1000;
    localparam logic [DATA_W-1:0] SAT32        = 32'hFFFF_FFFF;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_RATE_LIMIT      = 2'd0;
    localparam cfg_idx_t REG_UNLIMITED_LEVEL = 2'd1;
    localparam cfg_idx_t REG_WINDOW_MS       = 2'd2;

    // One logged send: tick stamp and byte count.
    typedef struct packed {
        logic [TICK_W-1:0] stamp;
        logic [DATA_W-1:0] bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result word.
    typedef struct packed {
        logic              allow_send;
        logic [DATA_W-1:0] window_bytes;
        logic              log_full;
    } result_t;

endpackage

[hdl/swsl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/swsl_out_buf.sv]
// Two-word result buffer between the limiter core and the output channel.
// Depends on swsl_pkg.
module swsl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swsl_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output swsl_pkg::result_t out_res
);
    import swsl_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_res;
        end
    end

endmodule

[hdl/sliding_window_send_limiter_top.sv]
// Sliding-window transmit rate limiter, top level.
// Depends on swsl_pkg, swsl_ram, swsl_out_buf and the assertion macro header.
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -----------------------------------------
//  in       in   in_valid/in_ready    sent_bytes[19:0]
//  out      out  out_valid/out_ready  allow_send, window_bytes[31:0], log_full
//  cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
// One tick word per cycle while in_ready is high; its result is written into a result buffer slot on acceptance.
// The limiter loop is a read-modify-write over the log RAM: the oldest entry
// is prefetched each cycle at the next head address, with a write forward.
// in_ready drops only when both result buffer slots are full.
// Reset and any register write empty the log; no clearing pass is needed.
// cfg_ready is always high.
`include "sliding_window_send_limiter_top_macros.svh"

module sliding_window_send_limiter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swsl_pkg::BYTES_W-1:0]       sent_bytes,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               allow_send,
    output logic [swsl_pkg::DATA_W-1:0]        window_bytes,
    output logic                               log_full,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  swsl_pkg::cfg_idx_t                 cfg_index,
    input  logic [swsl_pkg::DATA_W-1:0]        cfg_data
);
    import swsl_pkg::*;

    // Configuration registers
    logic [DATA_W-1:0] rate_limit_reg;
    logic [DATA_W-1:0] unlimited_level_reg;
    logic [WIN_W-1:0]  window_reg;

    // Log control state
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;   // exact total of live entries

    // Newest entry kept in flops so a merge needs no second RAM read
    logic [TICK_W-1:0] newest_time_reg;
    logic [DATA_W-1:0] newest_bytes_reg;

    // Read-during-write forward
    logic              hit_reg;
    entry_t            fwd_data_reg;

    // RAM port signals
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // Datapath
    logic              step, cfg_wr, cfg_hit;
    logic              limiting, expire, has_send, merge, append;
    logic [TICK_W-1:0] tick_inc, age;
    entry_t            head_ent;
    logic [CNT_W-1:0]  cnt_after;
    logic [DATA_W:0]   merge_sum;
    logic [DATA_W-1:0] merged_bytes;
    logic [SUM_W-1:0]  add_val, sub_val, sum_new;
    logic [DATA_W-1:0] window_sat;
    logic [PTR_W-1:0]  head_adv, tail_adv, last_idx;
    logic [CNT_W-1:0]  cnt_new;
    result_t           core_res, buf_res;
    logic              buf_ready;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        next_slot = (ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && ((cfg_index == REG_RATE_LIMIT)
                                 || (cfg_index == REG_UNLIMITED_LEVEL)
                                 || (cfg_index == REG_WINDOW_MS));
    assign in_ready  = buf_ready;
    assign step      = in_valid && buf_ready;

    always_comb
    begin
        tick_inc = tick_reg + 1'b1;
        limiting = (rate_limit_reg < unlimited_level_reg);
        head_ent = hit_reg ? fwd_data_reg : entry_t'(ram_rdata);

        // Expire the oldest entry once its age passes the window
        age       = tick_inc - head_ent.stamp;
        expire    = limiting && (cnt_reg != '0) && (age > TICK_W'(window_reg));
        cnt_after = cnt_reg - CNT_W'(expire);

        has_send = limiting && (sent_bytes != '0);
        merge    = has_send && (cnt_after == CNT_W'(LOG_DEPTH));
        append   = has_send && !merge;

        merge_sum    = {1'b0, newest_bytes_reg} + (DATA_W + 1)'(sent_bytes);
        merged_bytes = merge_sum[DATA_W] ? SAT32 : merge_sum[DATA_W-1:0];

        // Running total: add the new/merged bytes, drop the expired entry
        if (append)
        begin
            add_val = SUM_W'(sent_bytes);
        end
        else if (merge)
        begin
            add_val = SUM_W'(merged_bytes - newest_bytes_reg);
        end
        else
        begin
            add_val = '0;
        end
        sub_val    = expire ? SUM_W'(head_ent.bytes) : '0;
        sum_new    = sum_reg + add_val - sub_val;
        window_sat = (|sum_new[SUM_W-1:DATA_W]) ? SAT32 : sum_new[DATA_W-1:0];

        head_adv = expire ? next_slot(head_reg) : head_reg;
        tail_adv = append ? next_slot(tail_reg) : tail_reg;
        cnt_new  = cnt_after + CNT_W'(append);
        last_idx = (tail_reg == '0) ? PTR_W'(LOG_DEPTH - 1) : tail_reg - 1'b1;

        ram_we    = step && !cfg_hit && (append || merge);
        ram_waddr = append ? tail_reg : last_idx;
        ram_wdata = append ? entry_t'{stamp: tick_inc, bytes: DATA_W'(sent_bytes)}
                           : entry_t'{stamp: newest_time_reg, bytes: merged_bytes};

        core_res.allow_send   = !limiting || (window_sat < rate_limit_reg);
        core_res.window_bytes = window_sat;
        core_res.log_full     = merge;
    end

    // Next-state selection; a register write wins and empties the log
    always_comb
    begin
        tick_next = step ? tick_inc : tick_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        if (cfg_hit)
        begin
            head_next = '0;
            tail_next = '0;
            cnt_next  = '0;
            sum_next  = '0;
        end
        else if (step)
        begin
            head_next = head_adv;
            tail_next = tail_adv;
            cnt_next  = cnt_new;
            sum_next  = sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg      <= SAT32;
            unlimited_level_reg <= SAT32;
            window_reg          <= WINDOW_RESET;
            tick_reg            <= '0;
            head_reg            <= '0;
            tail_reg            <= '0;
            cnt_reg             <= '0;
            sum_reg             <= '0;
            hit_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_RATE_LIMIT:      rate_limit_reg      <= cfg_data;
                    REG_UNLIMITED_LEVEL: unlimited_level_reg <= cfg_data;
                    REG_WINDOW_MS:       window_reg          <= cfg_data[WIN_W-1:0];
                    default:             ;
                endcase
            end
            tick_reg <= tick_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            hit_reg  <= ram_we && (ram_waddr == head_next);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
        if (step && !cfg_hit && append)
        begin
            newest_time_reg  <= tick_inc;
            newest_bytes_reg <= DATA_W'(sent_bytes);
        end
        else if (step && !cfg_hit && merge)
        begin
            newest_bytes_reg <= merged_bytes;
        end
    end

    // Log RAM, read every cycle at the head address of the next cycle
    swsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    swsl_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (buf_ready),
        .in_res    (core_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (buf_res)
    );

    assign allow_send   = buf_res.allow_send;
    assign window_bytes = buf_res.window_bytes;
    assign log_full     = buf_res.log_full;

    // Checks
    `SWSL_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(LOG_DEPTH), "log count beyond depth")
    `SWSL_ASSERT_IMPL(a_merge_full, step && merge, cnt_reg == CNT_W'(LOG_DEPTH), "merge, not full")
    `SWSL_ASSERT_IMPL(a_off_empty, !limiting, sum_reg == '0 && cnt_reg == '0, "log not empty")
    `SWSL_ASSERT_NEXT(a_tick_adv, step, tick_reg == $past(tick_inc), "tick did not advance")

endmodule
